// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked during reset
`define VDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked property, also live during reset
`define VDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/vdc_pkg.sv =====
`default_nettype none
package vdc_pkg;
   localparam int DEF_MAX_KERNEL = 8;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int PIX_W    = 8;
   localparam int COEF_W   = 8;
   localparam int FILT_W   = 22;
   localparam int ACC_W    = 26;
   localparam int STEP_W   = 4;
   localparam int KCOUNT_W = 5;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int N_REGS   = 4;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KROWS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KCOLS  = 3'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // control handed from the sequencer to every cell
   typedef struct packed {
      logic                       load_tap;
      logic [2:0]                 tap_row;
      logic [2:0]                 tap_col;
      logic signed [COEF_W-1:0]   tap_val;
      logic                       shift;
      logic                       clear;
      logic                       mac;
      logic                       row_use;
      logic [STEP_W-1:0]          step;
      logic                       drain;
      logic [KCOUNT_W-1:0]        kcols;
   } vdc_ctl_type;
endpackage
`default_nettype wire

// ===== rtl/core/vdc_if.sv =====
`default_nettype none
interface vdc_req_if import vdc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [2:0]               tap_row;
   logic [2:0]               tap_col;
   logic signed [COEF_W-1:0] coefficient;
   logic [PIX_W-1:0]         pixel;
   modport source (output valid, operation, tap_row, tap_col, coefficient, pixel,
                   input ready);
   modport sink   (input valid, operation, tap_row, tap_col, coefficient, pixel,
                   output ready);
endinterface

interface vdc_rsp_if import vdc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [FILT_W-1:0] filtered;
   logic                     image_done;
   modport source (output valid, filtered, image_done, input ready);
   modport sink   (input valid, filtered, image_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/vdc_cell.sv =====
`default_nettype none
module vdc_cell import vdc_pkg::*; #(
   parameter int MAX_KERNEL = DEF_MAX_KERNEL,
   parameter int COL        = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vdc_ctl_type                   ctl,
   input  wire logic [MAX_KERNEL*PIX_W-1:0]   column_in,
   output logic      [MAX_KERNEL*PIX_W-1:0]   column_out,
   input  wire logic signed [ACC_W-1:0]       acc_in,
   output logic signed [ACC_W-1:0]            acc_out
);
   localparam int AB = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

   logic [PIX_W-1:0]         pix_ff [MAX_KERNEL];
   logic signed [COEF_W-1:0] tap_ff [MAX_KERNEL];
   logic signed [ACC_W-1:0]  acc_ff;
   logic [AB-1:0]            idx;
   logic signed [PIX_W+COEF_W:0] prod;
   logic                     use_col;

   // taps of this kernel column, reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < MAX_KERNEL; a++) tap_ff[a] <= '0;
      end else if (ctl.load_tap && (32'(ctl.tap_col) == COL)
                   && (32'(ctl.tap_row) < MAX_KERNEL)) begin
         tap_ff[AB'(ctl.tap_row)] <= ctl.tap_val;
      end
   end

   // window column, handed on to the next cell on each shift
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         for (int a = 0; a < MAX_KERNEL; a++) pix_ff[a] <= column_in[a*PIX_W +: PIX_W];
      end
   end

   always_comb begin
      for (int a = 0; a < MAX_KERNEL; a++) column_out[a*PIX_W +: PIX_W] = pix_ff[a];
   end

   assign idx     = AB'(ctl.step);
   assign prod    = $signed({1'b0, pix_ff[idx]}) * tap_ff[idx];
   assign use_col = ctl.row_use && (COL < 32'(ctl.kcols));

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.mac) begin
         if (use_col) acc_ff <= acc_ff + ACC_W'(prod);
      end else if (ctl.drain) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;
endmodule
`default_nettype wire

// ===== rtl/core/valid_2d_convolution_unit.sv =====
`default_nettype none
`include "assert_macros.svh"
// Valid-region 2D convolution (kernel flipped in both axes). A request word
// either loads one signed kernel tap (operation 0) or delivers one pixel in
// raster order (operation 1). Each pixel whose kernel window lies fully
// inside the image gives one response word with the signed sum and a flag on
// the last result of the image. The kernel is held in a chain of MAX_KERNEL
// cells, one per kernel column, each with its own multiplier; the previous
// MAX_KERNEL-1 rows live in a single-port line store of MAX_WIDTH words, one
// vertical pixel column per word, which needs no clearing after reset.
// A tap load is taken without leaving the idle state; a pixel without a
// result passes a line store read, then column write and window shift; a
// pixel with a result also passes the multiply sweep over the kernel rows
// in every cell followed by draining the column sums along the cell chain.
// The response sits in an output register, so the next request is taken
// while a result still waits. Any write to a valid register index restarts
// the image at row 0, column 0.
module valid_2d_convolution_unit import vdc_pkg::*; #(
   parameter int MAX_KERNEL = DEF_MAX_KERNEL,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   vdc_req_if.sink                   req_if,
   vdc_rsp_if.source                 rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);
   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int KB = $clog2(MAX_KERNEL + 1);
   localparam int LW = MAX_KERNEL * PIX_W;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   // configuration registers
   logic [CSR_W-1:0] width_ff, height_ff;
   logic [3:0]       krows_ff, kcols_ff;
   logic [WB-1:0]    w_cl;
   logic [HB-1:0]    h_cl;
   logic [KB-1:0]    kr_cl, kc_cl;

   // raster position of the next pixel
   logic [CB-1:0] col_ff, col_in, c_cur;
   logic [RB-1:0] row_ff, row_in, r_cur;

   // item held while the sequencer works on it
   logic [CB-1:0]    addr_ff;
   logic [PIX_W-1:0] pix_ff;
   logic             produce_ff, last_ff;

   logic [2:0]           state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic signed [ACC_W-1:0] total_ff;

   // line store, one pixel column of the recent rows per word
   logic [LW-1:0]       line_mem [MAX_WIDTH];
   logic [LW-1:0]       rd_ff;
   logic [LW+PIX_W-1:0] col_full;
   logic [LW-1:0]       col_word;

   logic accept, pix_accept, cfg_hit, step_last, out_load;
   logic produce, last;
   logic out_valid_ff;
   logic signed [FILT_W-1:0] out_filt_ff;
   logic out_done_ff;

   vdc_ctl_type ctl;
   logic [LW-1:0]           col_chain [MAX_KERNEL];
   logic signed [ACC_W-1:0] acc_chain [MAX_KERNEL];

   assign accept     = req_if.valid && req_if.ready;
   assign pix_accept = accept && (req_if.operation == OP_PIXEL);
   assign req_if.ready = (state_ff == S_IDLE);

   // register write decoder
   always_comb begin
      unique case (csr_index) inside
         REG_WIDTH, REG_HEIGHT, REG_KROWS, REG_KCOLS: cfg_hit = csr_we;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
         krows_ff  <= 4'd3;
         kcols_ff  <= 4'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata;
            REG_KROWS:  krows_ff  <= csr_wdata[3:0];
            REG_KCOLS:  kcols_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, anything above the maximum as the maximum
   assign w_cl  = (width_ff == '0) ? WB'(1) :
                  (32'(width_ff) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(width_ff);
   assign h_cl  = (height_ff == '0) ? HB'(1) :
                  (32'(height_ff) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(height_ff);
   assign kr_cl = (krows_ff == '0) ? KB'(1) :
                  (32'(krows_ff) > MAX_KERNEL) ? KB'(MAX_KERNEL) : KB'(krows_ff);
   assign kc_cl = (kcols_ff == '0) ? KB'(1) :
                  (32'(kcols_ff) > MAX_KERNEL) ? KB'(MAX_KERNEL) : KB'(kcols_ff);

   // position of this pixel and of the next one
   always_comb begin
      c_cur   = (32'(col_ff) >= 32'(w_cl)) ? '0 : col_ff;
      r_cur   = (32'(row_ff) >= 32'(h_cl)) ? '0 : row_ff;
      last    = (32'(r_cur) + 1 == 32'(h_cl)) && (32'(c_cur) + 1 == 32'(w_cl));
      produce = (32'(r_cur) + 1 >= 32'(kr_cl)) && (32'(c_cur) + 1 >= 32'(kc_cl));
      if (32'(c_cur) + 1 >= 32'(w_cl)) begin
         col_in = '0;
         row_in = (32'(r_cur) + 1 >= 32'(h_cl)) ? '0 : RB'(32'(r_cur) + 1);
      end else begin
         col_in = CB'(32'(c_cur) + 1);
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         addr_ff    <= c_cur;
         pix_ff     <= req_if.pixel;
         produce_ff <= produce;
         last_ff    <= last;
      end
   end

   // line store: read on accept, write back the updated column in the shift state
   always_ff @(posedge clock) begin
      if (pix_accept) rd_ff <= line_mem[c_cur];
      if (state_ff == S_SHIFT) line_mem[addr_ff] <= col_word;
   end

   // new pixel on top, older rows move down by one
   assign col_full = {rd_ff, pix_ff};
   assign col_word = col_full[LW-1:0];

   assign step_last = (32'(step_ff) == MAX_KERNEL - 1);
   assign out_load  = (state_ff == S_OUT) && (!out_valid_ff || rsp_if.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE:  if (pix_accept) state_in = S_SHIFT;
         S_SHIFT: begin
            step_in  = '0;
            state_in = produce_ff ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            step_in = step_last ? '0 : step_ff + 1'b1;
            if (step_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            step_in = step_last ? '0 : step_ff + 1'b1;
            if (step_last) state_in = S_OUT;
         end
         S_OUT:   if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // column sums leave the chain at cell 0, one per drain cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_SHIFT) total_ff <= '0;
      else if (state_ff == S_DRAIN) total_ff <= total_ff + acc_chain[0];
   end

   // control word for the cells
   always_comb begin
      ctl.load_tap = accept && (req_if.operation == OP_LOAD);
      ctl.tap_row  = req_if.tap_row;
      ctl.tap_col  = req_if.tap_col;
      ctl.tap_val  = req_if.coefficient;
      ctl.shift    = (state_ff == S_SHIFT);
      ctl.clear    = (state_ff == S_SHIFT);
      ctl.mac      = (state_ff == S_MAC);
      ctl.row_use  = (32'(step_ff) < 32'(kr_cl));
      ctl.step     = step_ff;
      ctl.drain    = (state_ff == S_DRAIN);
      ctl.kcols    = KCOUNT_W'(kc_cl);
   end

   for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_cell
      logic [LW-1:0]           cin;
      logic signed [ACC_W-1:0] ain;
      if (b == 0) begin : g_first
         assign cin = col_word;
      end else begin : g_next
         assign cin = col_chain[b-1];
      end
      if (b == MAX_KERNEL - 1) begin : g_end
         assign ain = '0;
      end else begin : g_mid
         assign ain = acc_chain[b+1];
      end
      vdc_cell #(.MAX_KERNEL(MAX_KERNEL), .COL(b)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .column_in  (cin),
         .column_out (col_chain[b]),
         .acc_in     (ain),
         .acc_out    (acc_chain[b])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_filt_ff <= total_ff[FILT_W-1:0];
         out_done_ff <= last_ff;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.filtered   = out_filt_ff;
   assign rsp_if.image_done = out_done_ff;

   `VDC_ASSERT(a_col_range, clock, reset, 32'(col_ff) < 32'(w_cl), "column beyond width")
   `VDC_ASSERT(a_cfg_restart, clock, reset, cfg_hit |=> (col_ff == '0 && row_ff == '0), "no restart")
   `VDC_ASSERT(a_rsp_source, clock, reset, $rose(rsp_if.valid) |-> $past(state_ff == S_OUT), "stray word")
   `VDC_ASSERT_ALWAYS(a_step_range, clock, (state_ff == S_MAC) |-> (32'(step_ff) < MAX_KERNEL), "step")
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import vdc_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SETTLE_WAIT  = 2 * DEF_MAX_KERNEL + 20;   // worst result latency plus margin
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_WORDS = 700;
   localparam int LAST_INDEX   = (1 << CSR_IDX_W) - 1;

   typedef struct {
      logic signed [FILT_W-1:0] filtered;
      logic                     image_done;
   } conv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   vdc_req_if req_bus ();
   vdc_rsp_if rsp_bus ();

   valid_2d_convolution_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus.sink),
      .rsp_if    (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock, high then low
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow of the filter state
   // ---------------------------------------------------------------
   logic [PIX_W-1:0]         shadow_lines [DEF_MAX_KERNEL][DEF_MAX_WIDTH];
   logic signed [COEF_W-1:0] shadow_taps  [DEF_MAX_KERNEL][DEF_MAX_KERNEL];
   int unsigned shadow_row, shadow_col;
   int unsigned cfg_width, cfg_height, cfg_krows, cfg_kcols;

   conv_result_type expected_results [$];
   int error_count = 0;
   int cycle_count = 0;

   // idling controls, shared with the sender and the receiver process
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int hold_cycles     = 0;

   function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // a coefficient load or one pixel through the shadow model
   function automatic void predict_word(logic op, logic [2:0] tr, logic [2:0] tc,
                                        logic signed [COEF_W-1:0] coef,
                                        logic [PIX_W-1:0] pix);
      int unsigned w, h, kr, kc, r, c;
      int signed acc;
      conv_result_type res;
      if (op == OP_LOAD) begin
         shadow_taps[tr][tc] = coef;
         return;
      end
      w  = clamp_reg(cfg_width, DEF_MAX_WIDTH);
      h  = clamp_reg(cfg_height, DEF_MAX_HEIGHT);
      kr = clamp_reg(cfg_krows, DEF_MAX_KERNEL);
      kc = clamp_reg(cfg_kcols, DEF_MAX_KERNEL);
      r  = (shadow_row >= h) ? 0 : shadow_row;
      c  = (shadow_col >= w) ? 0 : shadow_col;
      shadow_lines[r % DEF_MAX_KERNEL][c] = pix;
      if (r + 1 >= kr && c + 1 >= kc) begin
         acc = 0;
         for (int a = 0; a < kr; a++)
            for (int b = 0; b < kc; b++)
               acc += $signed({1'b0, shadow_lines[(r - a) % DEF_MAX_KERNEL][c - b]})
                      * shadow_taps[a][b];
         res.filtered   = acc[FILT_W-1:0];
         res.image_done = (r == h - 1) && (c == w - 1);
         expected_results.push_back(res);
      end
      if (c + 1 >= w) begin
         c = 0;
         r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         c = c + 1;
      end
      shadow_row = r;
      shadow_col = c;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_LOAD;
      req_bus.tap_row     = '0;
      req_bus.tap_col     = '0;
      req_bus.coefficient = '0;
      req_bus.pixel       = '0;
   end

   // called and returns at a falling edge; valid stays up between words unless idling
   task automatic send_word(logic op, logic [2:0] tr, logic [2:0] tc,
                            logic signed [COEF_W-1:0] coef, logic [PIX_W-1:0] pix);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.tap_row     <= tr;
      req_bus.tap_col     <= tc;
      req_bus.coefficient <= coef;
      req_bus.pixel       <= pix;
      do @(posedge clock); while (!req_bus.ready);
      predict_word(op, tr, tc, coef, pix);
      @(negedge clock);
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] pix);
      send_word(OP_PIXEL, 3'($urandom), 3'($urandom), COEF_W'($urandom), pix);
   endtask

   task automatic send_tap(int tr, int tc, int coef);
      send_word(OP_LOAD, tr[2:0], tc[2:0], coef[COEF_W-1:0], PIX_W'($urandom));
   endtask

   // waits for all results plus the latency of a pixel that gives none
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_WIDTH:  cfg_width  = value & 11'h7ff;
         REG_HEIGHT: cfg_height = value & 11'h7ff;
         REG_KROWS:  cfg_krows  = value & 4'hf;
         REG_KCOLS:  cfg_kcols  = value & 4'hf;
         default:    return;   // unmapped index, no restart
      endcase
      shadow_row = 0;
      shadow_col = 0;
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned kr,
                               int unsigned kc);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_KROWS, kr);
      write_reg(REG_KCOLS, kc);
   endtask

   task automatic random_pixels(int n);
      for (int i = 0; i < n; i++) send_pixel(PIX_W'($urandom));
   endtask

   // ---------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------
   // receiver: random stall plus the long hold-off for the pressure test
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles   <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end
   initial rsp_bus.ready = 1'b0;

   always @(posedge clock) begin
      conv_result_type exp_res;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response word: filtered %0d image_done %0b",
                   rsp_bus.filtered, rsp_bus.image_done);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_bus.filtered !== exp_res.filtered) begin
               $error("filtered: expected %0d actual %0d", exp_res.filtered,
                      rsp_bus.filtered);
               error_count++;
            end
            if (rsp_bus.image_done !== exp_res.image_done) begin
               $error("image_done: expected %0b actual %0b", exp_res.image_done,
                      rsp_bus.image_done);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** valid_2d_convolution_unit: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   // extreme taps and pixels on a small image, every operation
   task automatic test_directed_extremes();
      set_geometry(4, 3, 3, 3);
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            send_tap(a, b, ((a + b) % 2) ? -128 : 127);
      send_tap(7, 7, -1);               // beyond kernel size, kept for later
      for (int i = 0; i < 12; i++) send_pixel((i % 2) ? 8'hff : 8'h00);
      // all taps at the negative extreme with saturated pixels: largest magnitude
      set_geometry(2, 2, 1, 1);
      send_tap(0, 0, -128);
      send_pixel(8'hff);
      send_tap(0, 0, 127);              // takes effect mid-image
      send_pixel(8'hff);
      send_pixel(8'h01);
      send_pixel(8'h80);
   endtask

   // out-of-range and unmapped register values
   task automatic test_register_clamping();
      set_geometry(0, 0, 0, 0);         // zero used as one: every pixel is a result
      random_pixels(3);
      set_geometry(5, 2047, 15, 15);    // clamps to maximum height and kernel
      for (int a = 0; a < DEF_MAX_KERNEL; a++)
         for (int b = 0; b < DEF_MAX_KERNEL; b++)
            send_tap(a, b, $urandom_range(255) - 128);
      set_geometry(9, 2047, 15, 15);
      random_pixels(9 * 9);
      // unmapped indexes must not restart the image
      set_geometry(3, 3, 2, 2);
      random_pixels(4);
      for (int idx = N_REGS; idx <= LAST_INDEX; idx++) write_reg(CSR_IDX_W'(idx), $urandom);
      random_pixels(5);
      // kernel larger than image: absorbed silently
      set_geometry(3, 2, 8, 8);
      random_pixels(12);
   endtask

   // widest row, a one-pixel image and a single-column image
   task automatic test_wide_image();
      set_geometry(DEF_MAX_WIDTH, 1, 1, 8);
      random_pixels(DEF_MAX_WIDTH);
      set_geometry(1, 1, 1, 1);
      random_pixels(3);
      set_geometry(1, 6, 4, 1);
      random_pixels(6);
   endtask

   // whole images with random content, a little noise and a few broken images
   task automatic test_random_images(int budget);
      int sent = 0;
      int unsigned w, h, kr, kc;
      while (sent < budget) begin
         w  = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
         h  = $urandom_range(10, 1);
         kr = ($urandom_range(9) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
         kc = ($urandom_range(9) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
         kr = clamp_reg(kr, DEF_MAX_KERNEL) > h ? $urandom_range(h, 1) : kr;
         set_geometry(w, h, kr, kc);
         repeat ($urandom_range(12)) send_tap($urandom_range(7), $urandom_range(7),
                                              $urandom_range(255) - 128);
         for (int i = 0; i < w * h * $urandom_range(2, 1); i++) begin
            if ($urandom_range(99) < 3)
               send_tap($urandom_range(7), $urandom_range(7), $urandom_range(255) - 128);
            if ($urandom_range(199) == 0) break;   // image cut short
            send_pixel(($urandom_range(7) == 0) ? 8'hff : 8'($urandom));
            sent++;
         end
      end
   endtask

   // long receiver hold-off while the sender keeps offering words
   task automatic test_backpressure();
      set_geometry(6, 6, 2, 2);
      for (int a = 0; a < 2; a++)
         for (int b = 0; b < 2; b++)
            send_tap(a, b, $urandom_range(255) - 128);
      hold_cycles = LONG_HOLD;
      random_pixels(36);
   endtask

   initial begin
      cfg_width  = 1024;
      cfg_height = 1024;
      cfg_krows  = 3;
      cfg_kcols  = 3;
      shadow_row = 0;
      shadow_col = 0;
      for (int a = 0; a < DEF_MAX_KERNEL; a++)
         for (int b = 0; b < DEF_MAX_KERNEL; b++)
            shadow_taps[a][b] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_register_clamping();
      test_wide_image();

      // idling phases: none, sender, receiver, both
      sender_idle_pct = 0;  recv_stall_pct = 0;
      test_random_images(RANDOM_WORDS / 4);
      sender_idle_pct = 49; recv_stall_pct = 0;
      test_random_images(RANDOM_WORDS / 4);
      sender_idle_pct = 0;  recv_stall_pct = 49;
      test_random_images(RANDOM_WORDS / 4);
      sender_idle_pct = 34; recv_stall_pct = 34;
      test_random_images(RANDOM_WORDS / 4);

      sender_idle_pct = 0;  recv_stall_pct = 0;
      test_backpressure();

      wait_idle();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("** valid_2d_convolution_unit: PASSED **");
      end else begin
         $display("** valid_2d_convolution_unit: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vdc_pkg.sv
rtl/core/vdc_if.sv
rtl/core/vdc_cell.sv
rtl/core/valid_2d_convolution_unit.sv
tb/sv/tb_top.sv
